// ===== rtl/core/md5_pkg.sv =====
// Package for the MD5 digest unit: round constants, rotate amounts, shared types.
// No dependencies.
`timescale 1ns / 1ps
package md5_pkg;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;
   localparam logic [7:0]  PAD_BYTE = 8'h80;
   localparam logic [5:0]  LEN_POS = 6'd56;

   typedef struct packed {
      logic       first;
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [1:0]  word_index;
      logic        last_word;
   } rsp_type;

   // datapath byte source
   typedef enum logic [1:0] {
      SRC_DATA = 2'd0,
      SRC_PAD  = 2'd1,
      SRC_ZERO = 2'd2,
      SRC_LEN  = 2'd3
   } src_type;

   typedef struct packed {
      logic    init;       // reload chaining words, clear count and total
      logic    wr;         // write one byte at fill position
      src_type src;
      logic    count;      // bump the byte total
      logic    start;      // load a..d from chaining words
      logic    round;      // one compression round
      logic    fold;       // add a..d back into chaining words
   } cmd_type;

   typedef struct packed {
      logic [5:0] fill;
      logic       round_last;
   } sts_type;

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
         6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
         6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
         6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
         6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
         6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
         6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
         6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
         6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
         6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
         6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
         6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
         default: k = 32'heb86d391;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] round_s(input logic [3:0] idx);
      logic [4:0] s;
      case (idx)
         4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
         4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
         4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
         4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15;
         default: s = 5'd21;
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/core/md5_if.sv =====
// Valid/ready channel interface carrying one payload of parameter type.
// Uses md5_pkg payload types at instantiation.
`timescale 1ns / 1ps
interface md5_if #(parameter type PAYLOAD_TYPE = logic) ();
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/md5_datapath.sv =====
// MD5 datapath: block store memory, length and fill counters, chaining words,
// one compression round per cycle. Depends on md5_pkg.
`timescale 1ns / 1ps
module md5_datapath (
   input  logic               clock,
   input  logic               reset,
   input  md5_pkg::cmd_type   cmd,
   input  logic [7:0]         data_byte,
   input  logic [1:0]         word_sel,
   output md5_pkg::sts_type   sts,
   output logic [31:0]        word_out
);
   // block store kept as sixteen little-endian message words
   logic [31:0] store_mem [16];
   logic [5:0]  fill_ff, fill_in;
   logic [5:0]  wr_pos;
   logic [60:0] total_ff, total_in;
   logic [31:0] h_ff [4];
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [5:0]  rnd_ff;
   logic [3:0]  g;
   logic [31:0] f, w, sum, rot;
   logic [4:0]  sh;
   logic [63:0] bits;
   logic [7:0]  wbyte;

   assign bits = {total_ff, 3'b000};

   always_comb begin
      case (cmd.src)
         md5_pkg::SRC_DATA: wbyte = data_byte;
         md5_pkg::SRC_PAD:  wbyte = md5_pkg::PAD_BYTE;
         md5_pkg::SRC_LEN:  wbyte = bits[{fill_ff[2:0], 3'b000} +: 8];
         default:           wbyte = 8'h00;
      endcase
   end

   // a new message writes its first byte at the start of the block
   assign wr_pos = cmd.init ? 6'd0 : fill_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr) store_mem[wr_pos[5:2]][{wr_pos[1:0], 3'b000} +: 8] <= wbyte;
   end

   always_comb begin
      fill_in  = fill_ff;
      total_in = total_ff;
      if (cmd.init) begin
         fill_in  = '0;
         total_in = '0;
      end
      if (cmd.wr) fill_in = fill_in + 6'd1;
      if (cmd.count) total_in = total_in + 61'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         total_ff <= '0;
      end else begin
         fill_ff  <= fill_in;
         total_ff <= total_in;
      end
   end

   // round function and message word index
   always_comb begin
      case (rnd_ff[5:4])
         2'd0: begin f = (b_ff & c_ff) | (~b_ff & d_ff); g = rnd_ff[3:0]; end
         2'd1: begin
            f = (d_ff & b_ff) | (~d_ff & c_ff);
            g = 4'(5 * rnd_ff[3:0] + 1);
         end
         2'd2: begin f = b_ff ^ c_ff ^ d_ff; g = 4'(3 * rnd_ff[3:0] + 5); end
         default: begin f = c_ff ^ (b_ff | ~d_ff); g = 4'(7 * rnd_ff[3:0]); end
      endcase
   end

   assign w   = store_mem[g];
   assign sh  = md5_pkg::round_s({rnd_ff[5:4], rnd_ff[1:0]});
   assign sum = a_ff + f + md5_pkg::round_k(rnd_ff) + w;
   assign rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff[0] <= md5_pkg::INIT_A;
         h_ff[1] <= md5_pkg::INIT_B;
         h_ff[2] <= md5_pkg::INIT_C;
         h_ff[3] <= md5_pkg::INIT_D;
         rnd_ff  <= '0;
      end else begin
         if (cmd.init) begin
            h_ff[0] <= md5_pkg::INIT_A;
            h_ff[1] <= md5_pkg::INIT_B;
            h_ff[2] <= md5_pkg::INIT_C;
            h_ff[3] <= md5_pkg::INIT_D;
         end
         if (cmd.start) begin
            a_ff <= h_ff[0]; b_ff <= h_ff[1]; c_ff <= h_ff[2]; d_ff <= h_ff[3];
            rnd_ff <= '0;
         end else if (cmd.round) begin
            a_ff <= d_ff; d_ff <= c_ff; c_ff <= b_ff; b_ff <= b_ff + rot;
            rnd_ff <= rnd_ff + 6'd1;
         end
         // fold arrives with the last round: add that round's outputs
         if (cmd.fold) begin
            h_ff[0] <= h_ff[0] + d_ff;
            h_ff[1] <= (h_ff[1] + b_ff) + rot;
            h_ff[2] <= h_ff[2] + b_ff;
            h_ff[3] <= h_ff[3] + c_ff;
         end
      end
   end

   assign sts.fill = fill_ff;
   assign sts.round_last = (rnd_ff == 6'd63);
   assign word_out = h_ff[word_sel];
endmodule

// ===== rtl/core/md5_control.sv =====
// MD5 controller: accepts items, sequences padding, compression and digest output.
// Depends on md5_pkg.
`timescale 1ns / 1ps
module md5_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  md5_pkg::req_type in_item,
   output md5_pkg::cmd_type cmd,
   input  md5_pkg::sts_type sts,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [1:0]       word_sel
);
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_PAD   = 7'b0000010,
      ST_ZERO  = 7'b0000100,
      ST_LEN   = 7'b0001000,
      ST_START = 7'b0010000,
      ST_ROUND = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   state_type  state_ff, state_in;
   logic       fin_ff, fin_in;     // compression belongs to the final message
   logic [1:0] sel_ff, sel_in;
   logic       take;

   assign in_ready  = (state_ff == ST_IDLE);
   assign take      = in_valid && in_ready;
   assign out_valid = (state_ff == ST_OUT);
   assign word_sel  = sel_ff;

   always_comb begin
      state_in = state_ff;
      fin_in   = fin_ff;
      sel_in   = sel_ff;
      cmd      = '0;
      cmd.src  = md5_pkg::SRC_DATA;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               cmd.init  = in_item.first;
               cmd.wr    = in_item.byte_valid;
               cmd.count = in_item.byte_valid;
               fin_in    = in_item.last;
               if (in_item.byte_valid && (in_item.first ? 1'b0 : (sts.fill == 6'd63)))
                  state_in = ST_START;
               else if (in_item.last)
                  state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            cmd.wr  = 1'b1;
            cmd.src = md5_pkg::SRC_PAD;
            // with no room for the length, finish this block and open another
            if (sts.fill == 6'd63) state_in = ST_START;
            else if (sts.fill == 6'd55) state_in = ST_LEN;
            else state_in = ST_ZERO;
         end
         ST_ZERO: begin
            cmd.wr  = 1'b1;
            cmd.src = md5_pkg::SRC_ZERO;
            if (sts.fill == 6'd63) state_in = ST_START;
            else if (sts.fill == 6'd55) state_in = ST_LEN;
         end
         ST_LEN: begin
            cmd.wr  = 1'b1;
            cmd.src = md5_pkg::SRC_LEN;
            if (sts.fill == 6'd63) state_in = ST_START;
         end
         ST_START: begin
            cmd.start = 1'b1;
            state_in  = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            if (sts.round_last) begin
               cmd.fold = 1'b1;
               if (!fin_ff) state_in = ST_IDLE;
               else if (sts.fill == md5_pkg::LEN_POS) state_in = ST_LEN;
               else if (sts.fill == 6'd0 && sel_ff == 2'd1) begin
                  state_in = ST_OUT;
                  sel_in   = 2'd0;
               end else begin
                  // full data block before the pad, or pad block needing another
                  state_in = (sel_ff == 2'd2) ? ST_ZERO : ST_PAD;
                  sel_in   = (sel_ff == 2'd2) ? 2'd1 : sel_ff;
               end
            end
         end
         ST_OUT: begin
            if (out_ready) begin
               sel_in = sel_ff + 2'd1;
               if (sel_ff == 2'd3) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // track padding progress in sel while not emitting
      if (state_ff == ST_PAD) sel_in = 2'd2;
      if (state_ff == ST_LEN) sel_in = 2'd1;
      if (state_ff == ST_IDLE) sel_in = 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fin_ff   <= 1'b0;
         sel_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fin_ff   <= fin_in;
         sel_ff   <= state_in == ST_OUT && state_ff != ST_OUT ? 2'd0 : sel_in;
      end
   end
endmodule

// ===== rtl/core/md5_message_digest_unit.sv =====
// MD5 digest unit: one byte per transfer, one byte per cycle while a block fills;
// each full block stalls input while the one-round-per-cycle compressor runs.
// A last transfer adds padding (one pad byte per cycle) and one or two
// compressions, then four result transfers. Synchronous active-high reset
// restores the standard chaining values and clears counts; the block store is not
// cleared. Depends on md5_pkg, md5_if, md5_control, md5_datapath.
`timescale 1ns / 1ps
module md5_message_digest_unit (
   input logic clock,
   input logic reset,
   md5_if.sink   req_chan,
   md5_if.source rsp_chan
);
   md5_pkg::cmd_type cmd;
   md5_pkg::sts_type sts;
   md5_pkg::req_type req_item;
   logic [1:0]  word_sel;
   logic [31:0] word_val;

   assign req_item = req_chan.payload;

   md5_control u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req_chan.valid), .in_ready(req_chan.ready), .in_item(req_item),
      .cmd(cmd), .sts(sts),
      .out_valid(rsp_chan.valid), .out_ready(rsp_chan.ready), .word_sel(word_sel)
   );

   md5_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .data_byte(req_item.data_byte),
      .word_sel(word_sel), .sts(sts), .word_out(word_val)
   );

   assign rsp_chan.payload = '{digest_word: word_val, word_index: word_sel,
                               last_word: (word_sel == 2'd3)};

   a_no_in_during_out: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready) else $error("input open during output");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && rsp_chan.payload.last_word |=> !rsp_chan.valid)
      else $error("output continues after last word");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.round && cmd.wr)) else $error("store written during rounds");
endmodule

// ===== test/md5_message_digest_unit_test.sv =====
// Self-checking testbench for md5_message_digest_unit: drives byte transfers,
// predicts digest words with its own MD5 model. Depends on md5_pkg, md5_if.
`timescale 1ns / 1ps
module md5_message_digest_unit_test;

   class digest_scoreboard;
      logic [31:0] chain[4];
      logic [7:0]  blk[64];
      int unsigned fill;
      logic [60:0] total;
      md5_pkg::rsp_type pending[$];
      int          errors;

      function new();
         load_init();
         fill = 0;
         errors = 0;
      endfunction

      function void load_init();
         chain[0] = md5_pkg::INIT_A; chain[1] = md5_pkg::INIT_B;
         chain[2] = md5_pkg::INIT_C; chain[3] = md5_pkg::INIT_D;
         fill = 0;
         total = '0;
      endfunction

      function logic [31:0] rotl(logic [31:0] v, int s);
         return (v << s) | (v >> (32 - s));
      endfunction

      function void compress();
         logic [31:0] w[16];
         logic [31:0] a, b, c, d, f, t;
         int g;
         int shifts[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
         logic [31:0] kc[64];
         for (int i = 0; i < 64; i++)
            kc[i] = $unsigned(32'(longint'($floor(
               4294967296.0 * (($sin(i + 1.0) < 0) ? -$sin(i + 1.0) : $sin(i + 1.0))))));
         for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
         a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
         for (int i = 0; i < 64; i++) begin
            if (i < 16) begin
               f = (b & c) | (~b & d); g = i;
            end else if (i < 32) begin
               f = (d & b) | (~d & c); g = (5*i + 1) % 16;
            end else if (i < 48) begin
               f = b ^ c ^ d; g = (3*i + 5) % 16;
            end else begin
               f = c ^ (b | ~d); g = (7*i) % 16;
            end
            t = d; d = c; c = b;
            b = b + rotl(a + f + kc[i] + w[g], shifts[(i/16)*4 + i%4]);
            a = t;
         end
         chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
      endfunction

      function void put_length();
         logic [63:0] bits;
         bits = {total, 3'b000};
         for (int k = 0; k < 8; k++) blk[56+k] = bits[8*k +: 8];
      endfunction

      function void note_request(md5_pkg::req_type r);
         md5_pkg::rsp_type e;
         if (r.first) load_init();
         if (r.byte_valid) begin
            blk[fill] = r.data_byte;
            total = total + 1;
            fill++;
            if (fill == 64) begin
               compress();
               fill = 0;
            end
         end
         if (!r.last) return;
         blk[fill] = md5_pkg::PAD_BYTE;
         for (int i = fill + 1; i < 64; i++) blk[i] = 8'h00;
         if (fill >= 56) begin
            compress();
            for (int i = 0; i < 56; i++) blk[i] = 8'h00;
         end
         put_length();
         compress();
         fill = 0;
         for (int k = 0; k < 4; k++) begin
            e.digest_word = chain[k];
            e.word_index = 2'(k);
            e.last_word = (k == 3);
            pending.push_back(e);
         end
      endfunction

      function void check_result(md5_pkg::rsp_type r);
         md5_pkg::rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected result word %h", r.digest_word);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (r.digest_word !== e.digest_word) begin
            $error("digest_word expected %h actual %h", e.digest_word, r.digest_word);
            errors++;
         end
         if (r.word_index !== e.word_index) begin
            $error("word_index expected %0d actual %0d", e.word_index, r.word_index);
            errors++;
         end
         if (r.last_word !== e.last_word) begin
            $error("last_word expected %0d actual %0d", e.last_word, r.last_word);
            errors++;
         end
      endfunction
   endclass

   localparam int STALL_LIMIT = 4000;

   logic clock;
   logic reset;
   md5_if #(.PAYLOAD_TYPE(md5_pkg::req_type)) req_chan ();
   md5_if #(.PAYLOAD_TYPE(md5_pkg::rsp_type)) rsp_chan ();
   digest_scoreboard board;
   int idle_cycles;
   int sent;
   int rsp_wait;

   md5_message_digest_unit dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready = 1'b0;
      reset = 1'b1;
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // result side: draw a wait per transfer, check every transfer
   always @(posedge clock) begin : rsp_side
      int w;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_wait <= 0;
      end else if (rsp_chan.valid && rsp_chan.ready) begin
         board.check_result(rsp_chan.payload);
         w = $urandom_range(0, 11);
         rsp_chan.ready <= (w == 0);
         rsp_wait <= (w == 0) ? 0 : w - 1;
      end else if (!rsp_chan.ready) begin
         if (rsp_wait == 0) rsp_chan.ready <= 1'b1;
         else rsp_wait <= rsp_wait - 1;
      end
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_byte(input logic first, input logic [7:0] data, input logic vld,
                            input logic last, input int gap);
      md5_pkg::req_type r;
      r.first = first; r.data_byte = data; r.byte_valid = vld; r.last = last;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload <= r;
      do @(posedge clock); while (!req_chan.ready);
      board.note_request(r);
      sent++;
   endtask

   task automatic send_message(input int len, input bit noisy);
      int gap;
      for (int i = 0; i <= len; i++) begin
         gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 11) : 0;
         send_byte(i == 0, 8'($urandom), i < len, i == len, gap);
         if (noisy && $urandom_range(0, 7) == 0)
            send_byte(1'b0, 8'($urandom), 1'b0, 1'b0, 0);
      end
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      int len;
      sent = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      // empty message, last without first after reset, extreme bytes
      send_byte(1'b1, 8'h00, 1'b0, 1'b1, 0);
      send_byte(1'b0, 8'hff, 1'b1, 1'b1, 0);
      send_byte(1'b1, 8'hff, 1'b1, 1'b0, 0);
      send_byte(1'b0, 8'h00, 1'b1, 1'b0, 1);
      send_byte(1'b0, 8'h55, 1'b0, 1'b0, 0);
      send_byte(1'b0, 8'haa, 1'b1, 1'b1, 0);
      // bytes after last carry on without a new first
      send_byte(1'b0, 8'h5a, 1'b1, 1'b1, 2);
      wait_drained();
      // lengths at the padding boundaries: 55, 56, 63, 64
      send_message(55, 0);
      send_message(56, 0);
      wait_drained();
      send_message(63, 0);
      send_message(64, 0);
      while (sent < 270) begin
         case ($urandom_range(0, 5))
            0: len = $urandom_range(0, 3);
            1: len = $urandom_range(54, 66);
            2: len = $urandom_range(118, 130);
            default: len = $urandom_range(0, 40);
         endcase
         // hold the run near its item budget
         if (sent + len > 275) len = 275 - sent;
         send_message(len, $urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) == 0)
            send_byte(1'b0, 8'($urandom), 1'($urandom), 1'b0, $urandom_range(0, 11));
      end
      wait_drained();
      repeat (200) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/core/md5_pkg.sv
rtl/core/md5_if.sv
rtl/core/md5_datapath.sv
rtl/core/md5_control.sv
rtl/core/md5_message_digest_unit.sv
test/md5_message_digest_unit_test.sv
